@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold whenever the antecedent holds.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// The condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant check failed");

`endif

@@ rtl/core/suv_pkg.sv @@
// ----------------------------------------------------------------------------
// Sphere UV mapping package
// Shared constants and the CORDIC arctangent table in binary angle units.
// ----------------------------------------------------------------------------
package suv_pkg;

   localparam int COORD_WIDTH_DEF  = 24;
   localparam int UV_FRAC_BITS_DEF = 16;
   localparam int CORDIC_STEPS_DEF = 18;

   // Coordinates are scaled into a 40-bit magnitude range.
   localparam int SCALED_BITS = 40;
   // CORDIC datapath width with headroom for the gain.
   localparam int CORE_WIDTH  = 43;
   // Angle width: a full turn is 2^32.
   localparam int ANGLE_WIDTH = 34;

   localparam logic signed [ANGLE_WIDTH-1:0] HALF_TURN    = ANGLE_WIDTH'(64'sd2147483648);
   localparam logic signed [ANGLE_WIDTH-1:0] QUARTER_TURN = ANGLE_WIDTH'(64'sd1073741824);

   function automatic logic [31:0] atan_turn(input int idx);
      logic [31:0] val;
      begin
         case (idx)
            0:  val = 32'h20000000;
            1:  val = 32'h12e4051f;
            2:  val = 32'h09fb385c;
            3:  val = 32'h051111d4;
            4:  val = 32'h028b0d43;
            5:  val = 32'h0145d7e2;
            6:  val = 32'h00a2f61e;
            7:  val = 32'h00517c55;
            8:  val = 32'h0028be53;
            9:  val = 32'h00145f2f;
            10: val = 32'h000a2f98;
            11: val = 32'h000517cc;
            12: val = 32'h00028be6;
            13: val = 32'h000145f3;
            14: val = 32'h0000a2f9;
            15: val = 32'h0000517d;
            16: val = 32'h000028be;
            17: val = 32'h0000145f;
            18: val = 32'h00000a30;
            19: val = 32'h00000518;
            20: val = 32'h0000028c;
            21: val = 32'h00000146;
            22: val = 32'h000000a3;
            23: val = 32'h00000051;
            24: val = 32'h00000029;
            25: val = 32'h00000014;
            26: val = 32'h0000000a;
            27: val = 32'h00000005;
            28: val = 32'h00000003;
            29: val = 32'h00000001;
            default: val = 32'h00000000;
         endcase
         return val;
      end
   endfunction

endpackage

@@ rtl/core/suv_isqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module suv_isqrt
   import suv_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [2*COORD_WIDTH-1:0]   in_value,
   output logic                       out_valid,
   output logic [COORD_WIDTH-1:0]     out_root
);

   localparam int W = COORD_WIDTH;

   logic [2*W-1:0] n_ff    [1:W];
   logic [W-1:0]   rem_ff  [1:W];
   logic [W-1:0]   root_ff [1:W];
   logic           vld_ff  [1:W];

   for (genvar k = 0; k < W; k++) begin : g_stage
      logic [2*W-1:0] n_src;
      logic [W-1:0]   rem_src;
      logic [W-1:0]   root_src;
      logic           vld_src;
      logic [W+1:0]   rem_sh;
      logic [W+1:0]   trial;
      logic           take;
      logic [W+1:0]   rem_in;

      if (k == 0) begin : g_first
         assign n_src    = in_value;
         assign rem_src  = '0;
         assign root_src = '0;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign n_src    = n_ff[k];
         assign rem_src  = rem_ff[k];
         assign root_src = root_ff[k];
         assign vld_src  = vld_ff[k];
      end

      assign rem_sh = {rem_src, n_src[2*W-1:2*W-2]};
      assign trial  = {root_src, 2'b01};
      assign take   = (rem_sh >= trial);
      assign rem_in = take ? (rem_sh - trial) : rem_sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_src;
         end
         n_ff[k+1]    <= {n_src[2*W-3:0], 2'b00};
         rem_ff[k+1]  <= rem_in[W-1:0];
         root_ff[k+1] <= {root_src[W-2:0], take};
      end
   end

   assign out_valid = vld_ff[W];
   assign out_root  = root_ff[W];

endmodule

@@ rtl/core/suv_cordic.sv @@
// ----------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// One rotation per register stage; returns the angle in binary turns.
// ----------------------------------------------------------------------------
module suv_cordic
   import suv_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [CORE_WIDTH-1:0]  in_x,
   input  logic signed [CORE_WIDTH-1:0]  in_y,
   input  logic signed [ANGLE_WIDTH-1:0] in_base,
   output logic                          out_valid,
   output logic signed [ANGLE_WIDTH-1:0] out_angle
);

   logic signed [CORE_WIDTH-1:0]  x_ff   [0:CORDIC_STEPS];
   logic signed [CORE_WIDTH-1:0]  y_ff   [0:CORDIC_STEPS];
   logic signed [ANGLE_WIDTH-1:0] ang_ff [0:CORDIC_STEPS];
   logic                          zero_ff[0:CORDIC_STEPS];
   logic                          vld_ff [0:CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      x_ff[0]    <= in_x;
      y_ff[0]    <= in_y;
      ang_ff[0]  <= in_base;
      zero_ff[0] <= (in_y == '0);
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CORE_WIDTH-1:0]  dx;
      logic signed [CORE_WIDTH-1:0]  dy;
      logic signed [ANGLE_WIDTH-1:0] step_ang;
      logic                          neg;
      logic signed [CORE_WIDTH-1:0]  x_in;
      logic signed [CORE_WIDTH-1:0]  y_in;
      logic signed [ANGLE_WIDTH-1:0] ang_in;

      assign dx       = y_ff[i] >>> i;
      assign dy       = x_ff[i] >>> i;
      assign step_ang = signed'(ANGLE_WIDTH'(atan_turn(i)));
      assign neg      = y_ff[i][CORE_WIDTH-1];
      assign x_in     = neg ? (x_ff[i] - dx) : (x_ff[i] + dx);
      assign y_in     = neg ? (y_ff[i] + dy) : (y_ff[i] - dy);
      assign ang_in   = zero_ff[i] ? ang_ff[i]
                      : (neg ? (ang_ff[i] - step_ang) : (ang_ff[i] + step_ang));

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         x_ff[i+1]    <= x_in;
         y_ff[i+1]    <= y_in;
         ang_ff[i+1]  <= ang_in;
         zero_ff[i+1] <= zero_ff[i];
      end
   end

   assign out_valid = vld_ff[CORDIC_STEPS];
   assign out_angle = ang_ff[CORDIC_STEPS];

endmodule

@@ rtl/core/sphere_uv_mapping_unit.sv @@
// Throughput: one vertex per cycle; busy is never raised.
// Latency is set by the square, sum, root (one bit per stage), CORDIC and output stages.
// Reset clears every valid bit; data registers are not reset.
// Results come one cycle wide on rsp_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Sphere UV mapping unit
// Equirectangular texture coordinates from a vertex position, fully pipelined.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sphere_uv_mapping_unit
   import suv_pkg::*;
#(
   parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
   parameter int UV_FRAC_BITS = UV_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   output logic                          rsp_valid,
   output logic [UV_FRAC_BITS:0]         rsp_tex_u,
   output logic [UV_FRAC_BITS:0]         rsp_tex_v
);

   localparam int W     = COORD_WIDTH;
   localparam int F     = UV_FRAC_BITS;
   localparam int PRE   = SCALED_BITS - W;
   localparam int DEPTH = W + 2;
   localparam logic signed [ANGLE_WIDTH-1:0] UV_HALF = ANGLE_WIDTH'(1) <<< (F - 1);
   localparam logic signed [ANGLE_WIDTH-1:0] UV_ONE  = ANGLE_WIDTH'(1) <<< F;
   localparam logic signed [ANGLE_WIDTH-1:0] RND_U   = ANGLE_WIDTH'(1) <<< (31 - F);
   localparam logic signed [ANGLE_WIDTH-1:0] RND_V   = ANGLE_WIDTH'(1) <<< (30 - F);

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Square stage, sum stage, and the coordinate delay line.
   logic signed [W-1:0] px_ff [0:DEPTH-1];
   logic signed [W-1:0] py_ff [0:DEPTH-1];
   logic signed [W-1:0] pz_ff [0:DEPTH-1];
   logic [W-1:0]        ax_in;
   logic [W-1:0]        az_in;
   logic [2*W-1:0]      sqx_ff;
   logic [2*W-1:0]      sqz_ff;
   logic [2*W-1:0]      sum_ff;
   logic                sq_vld_ff;
   logic                sum_vld_ff;

   assign ax_in = req_pos_x[W-1] ? W'(-req_pos_x) : W'(req_pos_x);
   assign az_in = req_pos_z[W-1] ? W'(-req_pos_z) : W'(req_pos_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff  <= 1'b0;
         sum_vld_ff <= 1'b0;
      end else begin
         sq_vld_ff  <= accept;
         sum_vld_ff <= sq_vld_ff;
      end
      sqx_ff   <= (2*W)'(ax_in) * (2*W)'(ax_in);
      sqz_ff   <= (2*W)'(az_in) * (2*W)'(az_in);
      sum_ff   <= sqx_ff + sqz_ff;
      px_ff[0] <= req_pos_x;
      py_ff[0] <= req_pos_y;
      pz_ff[0] <= req_pos_z;
   end

   for (genvar d = 1; d < DEPTH; d++) begin : g_delay
      always_ff @(posedge clock) begin
         px_ff[d] <= px_ff[d-1];
         py_ff[d] <= py_ff[d-1];
         pz_ff[d] <= pz_ff[d-1];
      end
   end

   logic         root_vld;
   logic [W-1:0] root;

   suv_isqrt #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_vld_ff),
      .in_value  (sum_ff),
      .out_valid (root_vld),
      .out_root  (root)
   );

   // CORDIC operands.
   logic signed [CORE_WIDTH-1:0]  cx;
   logic signed [CORE_WIDTH-1:0]  cz;
   logic signed [CORE_WIDTH-1:0]  lon_x;
   logic signed [CORE_WIDTH-1:0]  lon_y;
   logic signed [ANGLE_WIDTH-1:0] lon_base;
   logic signed [CORE_WIDTH-1:0]  lat_x;
   logic signed [CORE_WIDTH-1:0]  lat_y;

   assign cx       = CORE_WIDTH'(px_ff[DEPTH-1]) <<< PRE;
   assign cz       = CORE_WIDTH'(pz_ff[DEPTH-1]) <<< PRE;
   assign lon_x    = cx[CORE_WIDTH-1] ? -cx : cx;
   assign lon_y    = cx[CORE_WIDTH-1] ? -cz : cz;
   assign lon_base = !cx[CORE_WIDTH-1] ? '0
                   : (cz[CORE_WIDTH-1] ? -HALF_TURN : HALF_TURN);
   assign lat_x    = signed'(CORE_WIDTH'(root)) <<< PRE;
   assign lat_y    = CORE_WIDTH'(py_ff[DEPTH-1]) <<< PRE;

   logic                          lon_vld;
   logic                          lat_vld;
   logic signed [ANGLE_WIDTH-1:0] lon_ang;
   logic signed [ANGLE_WIDTH-1:0] lat_ang;

   suv_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic_lon (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (root_vld),
      .in_x      (lon_x),
      .in_y      (lon_y),
      .in_base   (lon_base),
      .out_valid (lon_vld),
      .out_angle (lon_ang)
   );

   suv_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic_lat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (root_vld),
      .in_x      (lat_x),
      .in_y      (lat_y),
      .in_base   ('0),
      .out_valid (lat_vld),
      .out_angle (lat_ang)
   );

   // Clamp the angles, scale to texture units, and register the beat.
   logic signed [ANGLE_WIDTH-1:0] lon_cl;
   logic signed [ANGLE_WIDTH-1:0] lat_cl;
   logic signed [ANGLE_WIDTH-1:0] u_raw;
   logic signed [ANGLE_WIDTH-1:0] v_raw;
   logic [F:0]                    tex_u_in;
   logic [F:0]                    tex_v_in;
   logic [F:0]                    tex_u_ff;
   logic [F:0]                    tex_v_ff;
   logic                          rsp_valid_ff;

   always_comb begin
      lon_cl = lon_ang;
      if (lon_ang > HALF_TURN) begin
         lon_cl = HALF_TURN;
      end else if (lon_ang < -HALF_TURN) begin
         lon_cl = -HALF_TURN;
      end
      lat_cl = lat_ang;
      if (lat_ang > QUARTER_TURN) begin
         lat_cl = QUARTER_TURN;
      end else if (lat_ang < -QUARTER_TURN) begin
         lat_cl = -QUARTER_TURN;
      end
      u_raw = UV_HALF + ((lon_cl + RND_U) >>> (32 - F));
      v_raw = UV_HALF - ((lat_cl + RND_V) >>> (31 - F));
      if (u_raw < 0) begin
         tex_u_in = '0;
      end else if (u_raw > UV_ONE) begin
         tex_u_in = UV_ONE[F:0];
      end else begin
         tex_u_in = u_raw[F:0];
      end
      if (v_raw < 0) begin
         tex_v_in = '0;
      end else if (v_raw > UV_ONE) begin
         tex_v_in = UV_ONE[F:0];
      end else begin
         tex_v_in = v_raw[F:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= lon_vld;
      end
      tex_u_ff <= tex_u_in;
      tex_v_ff <= tex_v_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_tex_u = tex_u_ff;
   assign rsp_tex_v = tex_v_ff;

   `ASSERT_ALWAYS(a_cordic_aligned, clock, reset, lon_vld == lat_vld)
   `ASSERT_IMPLY(a_u_range, clock, reset, rsp_valid, rsp_tex_u <= UV_ONE[F:0])
   `ASSERT_IMPLY(a_v_range, clock, reset, rsp_valid, rsp_tex_v <= UV_ONE[F:0])

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sphere UV mapping unit testbench
// Drives vertex positions through the command port in random bursts, predicts
// the equirectangular texture coordinates with a fixed-point CORDIC model and
// compares every result beat in order against the predicted coordinates.
// ----------------------------------------------------------------------------
module testbench
   import suv_pkg::*;
();

   localparam int CW = COORD_WIDTH_DEF;
   localparam int FB = UV_FRAC_BITS_DEF;
   localparam int NS = CORDIC_STEPS_DEF;
   localparam int LATENCY = CW + NS + 4;
   localparam int N_RANDOM = 1530;
   localparam longint CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } vertex_type;

   typedef struct packed {
      logic [FB:0] u;
      logic [FB:0] v;
   } texcoord_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [CW-1:0] req_pos_x = '0;
   logic signed [CW-1:0] req_pos_y = '0;
   logic signed [CW-1:0] req_pos_z = '0;
   logic rsp_valid;
   logic [FB:0] rsp_tex_u;
   logic [FB:0] rsp_tex_v;

   vertex_type vertex_queue[$];
   texcoord_type expected_uv[$];
   int gap_left = 0;
   int burst_left = 0;
   bit hold_for_drain = 1'b0;
   bit drain_done = 1'b0;
   bit stimulus_done = 1'b0;
   int mismatches = 0;
   int results_seen = 0;
   longint cycles = 0;

   sphere_uv_mapping_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .rsp_valid(rsp_valid), .rsp_tex_u(rsp_tex_u), .rsp_tex_v(rsp_tex_v)
   );

   always #5 clock = ~clock;

   function automatic longint floor_shift(longint val, int sh);
      return val >>> sh;
   endfunction

   function automatic longint root_floor(longint n);
      longint lo, hi, mid;
      lo = 0;
      hi = 64'd3037000499;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (mid * mid <= n) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic longint vector_angle(longint cx, longint cy);
      longint ang, dx, dy;
      ang = 0;
      if (cy == 0) return 0;
      for (int i = 0; i < NS && i < 30; i++) begin
         dx = floor_shift(cy, i);
         dy = floor_shift(cx, i);
         if (cy < 0) begin
            cx = cx - dx;
            cy = cy + dy;
            ang = ang - longint'(atan_turn(i));
         end else begin
            cx = cx + dx;
            cy = cy - dy;
            ang = ang + longint'(atan_turn(i));
         end
      end
      return ang;
   endfunction

   function automatic logic [FB:0] clamp_coord(longint val);
      if (val < 0) val = 0;
      if (val > (longint'(1) << FB)) val = longint'(1) << FB;
      return val[FB:0];
   endfunction

   function automatic texcoord_type map_vertex(vertex_type p);
      longint px, py, pz, cx, cz, base, lon, lat, rad, u, v;
      texcoord_type t;
      px = p.x;
      py = p.y;
      pz = p.z;
      cx = px <<< (40 - CW);
      cz = pz <<< (40 - CW);
      base = 0;
      if (cx < 0) begin
         base = (cz >= 0) ? (longint'(1) << 31) : -(longint'(1) << 31);
         cx = -cx;
         cz = -cz;
      end
      lon = base + vector_angle(cx, cz);
      if (lon > (longint'(1) << 31)) lon = longint'(1) << 31;
      if (lon < -(longint'(1) << 31)) lon = -(longint'(1) << 31);
      rad = root_floor(px * px + pz * pz);
      lat = vector_angle(rad <<< (40 - CW), py <<< (40 - CW));
      if (lat > (longint'(1) << 30)) lat = longint'(1) << 30;
      if (lat < -(longint'(1) << 30)) lat = -(longint'(1) << 30);
      u = (longint'(1) << (FB - 1))
          + floor_shift(lon + (longint'(1) << (31 - FB)), 32 - FB);
      v = (longint'(1) << (FB - 1))
          - floor_shift(lat + (longint'(1) << (30 - FB)), 31 - FB);
      t.u = clamp_coord(u);
      t.v = clamp_coord(v);
      return t;
   endfunction

   function automatic logic signed [CW-1:0] rand_coord();
      logic signed [CW-1:0] c;
      case ($urandom_range(0, 5))
         0: c = CW'($urandom_range(0, 3)) - CW'(1);
         1: c = $signed(CW'($urandom_range(0, 511))) - CW'(256);
         2: c = ($urandom_range(0, 1)) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
         3: c = '0;
         default: c = CW'($urandom);
      endcase
      return c;
   endfunction

   function automatic vertex_type make_vertex(logic signed [CW-1:0] x,
                                              logic signed [CW-1:0] y,
                                              logic signed [CW-1:0] z);
      vertex_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      return p;
   endfunction

   initial begin
      logic signed [CW-1:0] mx, mn;
      mx = {1'b0, {(CW-1){1'b1}}};
      mn = {1'b1, {(CW-1){1'b0}}};
      vertex_queue.push_back(make_vertex('0, '0, '0));
      vertex_queue.push_back(make_vertex('0, mx, '0));
      vertex_queue.push_back(make_vertex('0, mn, '0));
      vertex_queue.push_back(make_vertex('0, '1, '0));
      vertex_queue.push_back(make_vertex(mn, CW'(5), '0));
      vertex_queue.push_back(make_vertex('1, '0, '0));
      vertex_queue.push_back(make_vertex(mx, '0, '0));
      vertex_queue.push_back(make_vertex(CW'(1), CW'(-7), '0));
      vertex_queue.push_back(make_vertex(mn, '0, CW'(1)));
      vertex_queue.push_back(make_vertex(mn, '0, '1));
      vertex_queue.push_back(make_vertex(mx, mx, mx));
      vertex_queue.push_back(make_vertex(mn, mn, mn));
      vertex_queue.push_back(make_vertex(mx, mn, mn));
      vertex_queue.push_back(make_vertex(mn, mx, mx));
      vertex_queue.push_back(make_vertex('0, CW'(3), mx));
      vertex_queue.push_back(make_vertex('0, CW'(3), mn));
      vertex_queue.push_back(make_vertex('1, CW'(1), '1));
      vertex_queue.push_back(make_vertex(CW'(1), '1, CW'(1)));
      vertex_queue.push_back(make_vertex(mn, mx, '1));
      vertex_queue.push_back(make_vertex(CW'(-1000), CW'(1000), '1));
      for (int i = 0; i < N_RANDOM; i++)
         vertex_queue.push_back(make_vertex(rand_coord(), rand_coord(), rand_coord()));
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Sender: bursts and gaps, with one pause partway through that drains the pipeline.
   always @(posedge clock) begin
      bit fire;
      vertex_type p;
      texcoord_type t;
      fire = 1'b0;
      if (start && !busy) begin
         t = map_vertex(make_vertex(req_pos_x, req_pos_y, req_pos_z));
         expected_uv.push_back(t);
      end
      if (!reset) begin
         if (hold_for_drain) begin
            if (expected_uv.size() == 0) hold_for_drain = 1'b0;
         end else if (vertex_queue.size() == 800 && !drain_done) begin
            hold_for_drain = 1'b1;
            drain_done = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (vertex_queue.size() > 0 && !(start && busy)) begin
            fire = 1'b1;
         end
      end
      if (start && busy) begin
         // Hold the current beat until it is taken.
      end else if (fire) begin
         p = vertex_queue.pop_front();
         start <= 1'b1;
         req_pos_x <= p.x;
         req_pos_y <= p.y;
         req_pos_z <= p.z;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         end
      end else begin
         start <= 1'b0;
         if (vertex_queue.size() == 0 && !reset) stimulus_done = 1'b1;
      end
   end

   // Monitor: the receiver cannot stall, so every strobe is a beat.
   always @(posedge clock) begin
      texcoord_type want;
      cycles++;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_uv.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat u=%0d v=%0d", rsp_tex_u, rsp_tex_v);
         end else begin
            want = expected_uv.pop_front();
            if (rsp_tex_u !== want.u || rsp_tex_v !== want.v) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected u=%0d v=%0d, got u=%0d v=%0d",
                           results_seen, want.u, want.v, rsp_tex_u, rsp_tex_v);
            end
         end
      end
   end

   initial begin
      wait (stimulus_done);
      while (expected_uv.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (cycles >= CYCLE_LIMIT) begin
         $display("timed out with %0d results outstanding", expected_uv.size());
         $display("end of test: mismatches");
      end else begin
         $display("Checked %0d vertices, including axis, seam and extreme coordinates.",
                  results_seen);
         if (mismatches == 0 && expected_uv.size() == 0)
            $display("end of test: clean");
         else
            $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("timed out waiting for stimulus to finish");
      $display("end of test: mismatches");
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/suv_pkg.sv
rtl/core/suv_isqrt.sv
rtl/core/suv_cordic.sv
rtl/core/sphere_uv_mapping_unit.sv
verif/testbench.sv
